/* sv/pcpr_pkg.sv */
`default_nettype none

package pcpr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_OFS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_OFS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_IDX  = 3'd4;

  // byte offset codes
  localparam logic [1:0] OFS_BYTE_ZERO = 2'd0;
  localparam logic [1:0] OFS_BYTE_ONE  = 2'd1;
  localparam logic [1:0] OFS_BYTE_TWO  = 2'd2;
  localparam logic [1:0] OFS_NONE      = 2'd3;

  typedef struct packed {
    logic [8:0] fb_x;
    logic [5:0] fb_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;
  } result_t;

  function automatic logic [7:0] pick_byte(
    input logic [1:0] sel,
    input logic [7:0] b0,
    input logic [7:0] b1,
    input logic [7:0] b2
  );
    logic [7:0] res;
    unique case (sel)
      OFS_BYTE_ZERO: res = b0;
      OFS_BYTE_ONE:  res = b1;
      OFS_BYTE_TWO:  res = b2;
      OFS_NONE:      res = 8'd0;
      default:       res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/panel_chain_pixel_remapper_top.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | three stored bytes, frame_start
// out     | output    | out_valid / out_ready | framebuffer x/y, rgb levels, frame_done
// cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// one pixel per clock while in_ready is high; the single register stage
// puts a result in the output register in the cycle after its pixel is accepted.
// in_ready is high whenever the output register is empty or being drained.
// synchronous active-low reset clears the counters and valid and sets the
// configuration registers to their defaults; the result register is not reset.
`default_nettype none

module panel_chain_pixel_remapper_top #(
  parameter int unsigned PANEL_COLS_LOGICAL = 64,
  parameter int unsigned PANEL_ROWS_LOGICAL = 128,
  parameter int unsigned IMAGE_COLS         = 128,
  parameter int unsigned IMAGE_ROWS         = 256,
  parameter int unsigned PHYS_PANEL_COLS    = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          in_stored_byte_zero,
  input  wire logic [7:0]                          in_stored_byte_one,
  input  wire logic [7:0]                          in_stored_byte_two,
  input  wire logic                                in_frame_start,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [8:0]                               out_framebuffer_x,
  output logic [5:0]                               out_framebuffer_y,
  output logic [7:0]                               out_red_level,
  output logic [7:0]                               out_green_level,
  output logic [7:0]                               out_blue_level,
  output logic                                     out_frame_done,
  input  wire logic                                cfg_we,
  input  wire logic [pcpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pcpr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned CW  = $clog2(IMAGE_COLS);
  localparam int unsigned RW  = $clog2(IMAGE_ROWS);
  localparam int unsigned LXW = $clog2(PANEL_COLS_LOGICAL);
  localparam int unsigned LYW = $clog2(PANEL_ROWS_LOGICAL);

  // configuration registers
  logic [1:0] red_ofs_r, green_ofs_r, blue_ofs_r;
  logic [7:0] chain_map_r;
  logic [2:0] flip_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_ofs_r   <= pcpr_pkg::OFS_BYTE_ZERO;
      green_ofs_r <= pcpr_pkg::OFS_BYTE_ONE;
      blue_ofs_r  <= pcpr_pkg::OFS_BYTE_TWO;
      chain_map_r <= 8'd228;
      flip_idx_r  <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcpr_pkg::REG_RED_OFS:   red_ofs_r   <= cfg_wdata[1:0];
        pcpr_pkg::REG_GREEN_OFS: green_ofs_r <= cfg_wdata[1:0];
        pcpr_pkg::REG_BLUE_OFS:  blue_ofs_r  <= cfg_wdata[1:0];
        pcpr_pkg::REG_CHAIN_MAP: chain_map_r <= cfg_wdata;
        pcpr_pkg::REG_FLIP_IDX:  flip_idx_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // position counters: image column/row plus local coordinate and panel parity,
  // tracked incrementally so no division is needed
  logic [CW-1:0]  col_r, col_nxt, col_c;
  logic [RW-1:0]  row_r, row_nxt, row_c;
  logic [LXW-1:0] lx_r, lx_nxt, lx_c;
  logic [LYW-1:0] ly_r, ly_nxt, ly_c;
  logic           pc_r, pc_nxt, pc_c;
  logic           pr_r, pr_nxt, pr_c;

  logic             accept;
  logic             out_valid_r;
  pcpr_pkg::result_t res_r, res_nxt;

  logic [1:0]     chain;
  logic           flip;
  logic [LXW-1:0] lx_f;
  logic [LYW-1:0] ly_f;
  logic           col_last, row_last;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // frame_start restarts this pixel at the origin
    col_c = in_frame_start ? '0 : col_r;
    row_c = in_frame_start ? '0 : row_r;
    lx_c  = in_frame_start ? '0 : lx_r;
    ly_c  = in_frame_start ? '0 : ly_r;
    pc_c  = in_frame_start ? 1'b0 : pc_r;
    pr_c  = in_frame_start ? 1'b0 : pr_r;

    col_last = (col_c == CW'(IMAGE_COLS - 1));
    row_last = (row_c == RW'(IMAGE_ROWS - 1));

    chain = chain_map_r[{pr_c, pc_c, 1'b0} +: 2];
    flip  = ({1'b0, chain} >= flip_idx_r);
    lx_f  = flip ? (LXW'(PANEL_COLS_LOGICAL - 1) - lx_c) : lx_c;
    ly_f  = flip ? (LYW'(PANEL_ROWS_LOGICAL - 1) - ly_c) : ly_c;

    res_nxt.fb_x = 9'(int'(chain) * PHYS_PANEL_COLS) + 9'(PHYS_PANEL_COLS - 1) - 9'(ly_f);
    res_nxt.fb_y = 6'(lx_f);
    res_nxt.red   = pcpr_pkg::pick_byte(red_ofs_r, in_stored_byte_zero,
                                        in_stored_byte_one, in_stored_byte_two);
    res_nxt.green = pcpr_pkg::pick_byte(green_ofs_r, in_stored_byte_zero,
                                        in_stored_byte_one, in_stored_byte_two);
    res_nxt.blue  = pcpr_pkg::pick_byte(blue_ofs_r, in_stored_byte_zero,
                                        in_stored_byte_one, in_stored_byte_two);
    res_nxt.frame_done = col_last && row_last;

    // advance column, wrapping into the next row
    if (col_last) begin
      col_nxt = '0;
      lx_nxt  = '0;
      pc_nxt  = 1'b0;
      if (row_last) begin
        row_nxt = '0;
        ly_nxt  = '0;
        pr_nxt  = 1'b0;
      end else begin
        row_nxt = row_c + RW'(1);
        if (ly_c == LYW'(PANEL_ROWS_LOGICAL - 1)) begin
          ly_nxt = '0;
          pr_nxt = !pr_c;
        end else begin
          ly_nxt = ly_c + LYW'(1);
          pr_nxt = pr_c;
        end
      end
    end else begin
      col_nxt = col_c + CW'(1);
      row_nxt = row_c;
      ly_nxt  = ly_c;
      pr_nxt  = pr_c;
      if (lx_c == LXW'(PANEL_COLS_LOGICAL - 1)) begin
        lx_nxt = '0;
        pc_nxt = !pc_c;
      end else begin
        lx_nxt = lx_c + LXW'(1);
        pc_nxt = pc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      lx_r  <= '0;
      ly_r  <= '0;
      pc_r  <= 1'b0;
      pr_r  <= 1'b0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      lx_r  <= lx_nxt;
      ly_r  <= ly_nxt;
      pc_r  <= pc_nxt;
      pr_r  <= pr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_framebuffer_x = res_r.fb_x;
  assign out_framebuffer_y = res_r.fb_y;
  assign out_red_level     = res_r.red;
  assign out_green_level   = res_r.green;
  assign out_blue_level    = res_r.blue;
  assign out_frame_done    = res_r.frame_done;

`ifndef ASSERT_OFF
  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word did not reach the output register");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(IMAGE_COLS - 1))
    else $error("column counter out of range");

  a_col_origin_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r == '0) |-> (lx_r == '0 && !pc_r))
    else $error("local x or panel column not at origin with column zero");

  a_frame_start_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_frame_start) |=> (col_r == CW'(1) && row_r == '0 && ly_r == '0 && !pr_r))
    else $error("frame start did not restart the counters");
`endif

endmodule

`default_nettype wire
